// File: rtl/touch_sensor_window_debouncer_top_assert.svh
// Assertion macros for the touch sensor window debouncer checker.
`ifndef TOUCH_SENSOR_WINDOW_DEBOUNCER_TOP_ASSERT_SVH
`define TOUCH_SENSOR_WINDOW_DEBOUNCER_TOP_ASSERT_SVH

// same-cycle implication, gated by reset
`define TSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, gated by reset
`define TSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tsd_pkg.sv
// Shared types and constants for the touch sensor window debouncer.
package tsd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int CNT_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_THR    = 2'd2;

    localparam logic [CNT_W-1:0] DEBOUNCE_THR_RST = 8'd2;
    localparam logic [CNT_W-1:0] FAULT_THR_RST    = 8'd5;
    localparam logic [CNT_W-1:0] CNT_MAX          = '1;

    localparam logic OP_POLL     = 1'b0;
    localparam logic OP_BASELINE = 1'b1;

    // millivolt window limits and converter full scale
    localparam int MV_FULL_SCALE = 5000;
    localparam int MV_PRESS_LO   = 850;
    localparam int MV_PRESS_HI   = 950;
    localparam int MV_RELEASE    = 4800;

    typedef enum logic [1:0] {
        CLS_INVALID  = 2'd0,
        CLS_PRESSED  = 2'd1,
        CLS_RELEASED = 2'd2
    } cls_t;

    typedef struct packed {
        logic             enable;
        logic [CNT_W-1:0] debounce_thr;
        logic [CNT_W-1:0] fault_thr;
    } cfg_t;

    typedef struct packed {
        logic baseline;
        cls_t cls;
    } item_t;

    typedef struct packed {
        cls_t raw_class;
        cls_t stable;
        logic changed;
        logic fault;
    } res_t;

endpackage

// File: rtl/tsd_in_if.sv
// Input channel: opcode and raw converter sample.
interface tsd_in_if #(
    parameter int ADC_BITS = 10
);
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [ADC_BITS-1:0] adc_sample;

    modport source (output valid, output opcode, output adc_sample, input ready);
    modport sink   (input valid, input opcode, input adc_sample, output ready);
endinterface

// File: rtl/tsd_out_if.sv
// Output channel: classification, debounced state, event and fault.
interface tsd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] raw_class;
    logic [1:0] stable_out;
    logic       state_changed;
    logic       fault;

    modport source (output valid, output raw_class, output stable_out,
                    output state_changed, output fault, input ready);
    modport sink   (input valid, input raw_class, input stable_out,
                    input state_changed, input fault, output ready);
    modport mon    (input valid, input raw_class, input stable_out,
                    input state_changed, input fault, input ready);
endinterface

// File: rtl/tsd_classify.sv
// Window comparator: maps a raw sample to invalid, pressed or released.
module tsd_classify #(
    parameter int ADC_BITS = 10
) (
    input  logic [ADC_BITS-1:0] sample,
    output tsd_pkg::cls_t       cls
);
    import tsd_pkg::*;

    // mv = floor(s*5000/full); mv limits turned into sample codes at elaboration
    localparam int FULL     = (1 << ADC_BITS) - 1;
    localparam int LO_CODE  = ((MV_PRESS_LO + 1) * FULL + MV_FULL_SCALE - 1) / MV_FULL_SCALE;
    localparam int HI_CODE  = (MV_PRESS_HI * FULL + MV_FULL_SCALE - 1) / MV_FULL_SCALE;
    localparam int REL_CODE = ((MV_RELEASE + 1) * FULL + MV_FULL_SCALE - 1) / MV_FULL_SCALE;

    localparam logic [ADC_BITS-1:0] LO_SAMPLE  = ADC_BITS'(LO_CODE);
    localparam logic [ADC_BITS-1:0] HI_SAMPLE  = ADC_BITS'(HI_CODE);
    localparam logic [ADC_BITS-1:0] REL_SAMPLE = ADC_BITS'(REL_CODE);

    always_comb
    begin
        priority if (sample >= REL_SAMPLE)
        begin
            cls = CLS_RELEASED;
        end
        else if (sample >= LO_SAMPLE && sample < HI_SAMPLE)
        begin
            cls = CLS_PRESSED;
        end
        else
        begin
            cls = CLS_INVALID;
        end
    end
endmodule

// File: rtl/tsd_cfg.sv
// Configuration registers written through the plain write port.
module tsd_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           we,
    input  logic [tsd_pkg::CFG_IDX_W-1:0]  index,
    input  logic [tsd_pkg::CFG_DATA_W-1:0] data,
    output tsd_pkg::cfg_t                  cfg
);
    import tsd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable       <= 1'b0;
            cfg_reg.debounce_thr <= DEBOUNCE_THR_RST;
            cfg_reg.fault_thr    <= FAULT_THR_RST;
        end
        else if (we)
        begin
            unique case (index)
                REG_ENABLE:       cfg_reg.enable       <= data[0];
                REG_DEBOUNCE_THR: cfg_reg.debounce_thr <= data[CNT_W-1:0];
                REG_FAULT_THR:    cfg_reg.fault_thr    <= data[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

// File: rtl/tsd_core.sv
// Fault tracker and counter debouncer state with per-transaction update.
module tsd_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  tsd_pkg::item_t item,
    input  tsd_pkg::cfg_t  cfg,
    output tsd_pkg::res_t  res
);
    import tsd_pkg::*;

    cls_t             stable_reg, stable_next;
    cls_t             cand_reg, cand_next;
    logic [CNT_W-1:0] dcnt_reg, dcnt_next;
    logic [CNT_W-1:0] inv_reg, inv_next;
    logic             fault_reg, fault_next;
    logic             changed;
    logic [CNT_W-1:0] inv_sat;
    logic [CNT_W-1:0] dcnt_sat;

    assign inv_sat  = (inv_reg == CNT_MAX) ? inv_reg : inv_reg + 1'b1;
    assign dcnt_sat = (dcnt_reg == CNT_MAX) ? dcnt_reg : dcnt_reg + 1'b1;

    always_comb
    begin
        stable_next = stable_reg;
        cand_next   = cand_reg;
        dcnt_next   = dcnt_reg;
        inv_next    = inv_reg;
        fault_next  = fault_reg;
        changed     = 1'b0;

        if (item.baseline || cfg.enable)
        begin
            if (item.cls == CLS_INVALID)
            begin
                inv_next = inv_sat;
                if (inv_sat >= cfg.fault_thr)
                begin
                    fault_next = 1'b1;
                end
            end
            else
            begin
                inv_next   = '0;
                fault_next = 1'b0;
            end
        end

        if (item.baseline)
        begin
            stable_next = item.cls;
        end
        else if (cfg.enable)
        begin
            if (item.cls != stable_reg)
            begin
                if (item.cls == cand_reg)
                begin
                    dcnt_next = dcnt_sat;
                    if (dcnt_sat >= cfg.debounce_thr)
                    begin
                        stable_next = item.cls;
                        dcnt_next   = '0;
                        changed     = 1'b1;
                    end
                end
                else
                begin
                    cand_next = item.cls;
                    dcnt_next = CNT_W'(1);
                end
            end
            else
            begin
                dcnt_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= CLS_INVALID;
            cand_reg   <= CLS_INVALID;
            dcnt_reg   <= '0;
            inv_reg    <= '0;
            fault_reg  <= 1'b0;
        end
        else if (load)
        begin
            stable_reg <= stable_next;
            cand_reg   <= cand_next;
            dcnt_reg   <= dcnt_next;
            inv_reg    <= inv_next;
            fault_reg  <= fault_next;
        end
    end

    assign res.raw_class = item.cls;
    assign res.stable    = stable_next;
    assign res.changed   = changed;
    assign res.fault     = fault_next;
endmodule

// File: rtl/touch_sensor_window_debouncer_top.sv
// Top level of the touch sensor window debouncer.
//
//   channel   dir   handshake        payload
//   in_ch     in    valid/ready      opcode, adc_sample
//   out_ch    out   valid/ready      raw_class, stable_out, state_changed, fault
//   cfg       in    cfg_we           cfg_index, cfg_data
//
// One transaction per cycle while out_ch is not stalled; input and result registered.
// Throughput is set by the state update in the core between the two registers.
// Reset clears valid flags, state and config registers to defaults; no clearing pass.
// A stalled output holds its result while one more transaction waits in the input register.
module touch_sensor_window_debouncer_top #(
    parameter int ADC_BITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    tsd_in_if.sink                         in_ch,
    tsd_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [tsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tsd_pkg::*;

    cfg_t  cfg;
    cls_t  in_cls;
    item_t in_item;
    item_t s1_item_reg;
    logic  s1_valid_reg, s1_valid_next;
    res_t  res;
    res_t  res_reg;
    logic  out_valid_reg, out_valid_next;
    logic  in_fire;
    logic  adv;

    tsd_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    tsd_classify #(
        .ADC_BITS (ADC_BITS)
    ) u_classify (
        .sample (in_ch.adc_sample),
        .cls    (in_cls)
    );

    assign in_item.baseline = (in_ch.opcode == OP_BASELINE);
    assign in_item.cls      = in_cls;

    assign adv         = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || adv;
    assign in_fire     = in_ch.valid && in_ch.ready;

    tsd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (adv),
        .item  (s1_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_item;
        end
        if (adv)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.raw_class     = res_reg.raw_class;
    assign out_ch.stable_out    = res_reg.stable;
    assign out_ch.state_changed = res_reg.changed;
    assign out_ch.fault         = res_reg.fault;
endmodule

// File: rtl/tsd_checker.sv
// Port-level assertion checker for the debouncer top, with its bind.
`include "touch_sensor_window_debouncer_top_assert.svh"

module tsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] raw_class,
    input logic [1:0] stable_out,
    input logic       state_changed,
    input logic       fault
);
    import tsd_pkg::*;

    `TSD_ASSERT_IMPLY(a_codes_legal, clk, rst_n, out_valid,
        (raw_class == CLS_INVALID || raw_class == CLS_PRESSED ||
         raw_class == CLS_RELEASED) &&
        (stable_out == CLS_INVALID || stable_out == CLS_PRESSED ||
         stable_out == CLS_RELEASED), "illegal class code on output")
    `TSD_ASSERT_IMPLY(a_change_takes_class, clk, rst_n, out_valid && state_changed,
        stable_out == raw_class, "state change did not adopt sample class")
    `TSD_ASSERT_IMPLY(a_valid_change_clears_fault, clk, rst_n,
        out_valid && state_changed && raw_class != CLS_INVALID, !fault,
        "fault still set after a change to a valid state")
    `TSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(raw_class) && $stable(stable_out) &&
        $stable(state_changed) && $stable(fault), "stalled result changed")
endmodule

bind touch_sensor_window_debouncer_top tsd_checker u_tsd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .raw_class     (out_ch.raw_class),
    .stable_out    (out_ch.stable_out),
    .state_changed (out_ch.state_changed),
    .fault         (out_ch.fault)
);

// File: tb/tb_touch_sensor_window_debouncer_top.sv
// Self-checking testbench for the touch sensor window debouncer: random traffic, scoreboard.
module tb_touch_sensor_window_debouncer_top;
    import tsd_pkg::*;

    localparam int ADC_BITS     = 10;
    localparam int ADC_FULL     = (1 << ADC_BITS) - 1;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;

    // sample bands that fall in each class window
    localparam int PRESS_MIN   = 175;
    localparam int PRESS_MAX   = 194;
    localparam int RELEASE_MIN = 983;

    typedef struct {
        logic                op;
        logic [ADC_BITS-1:0] sample;
    } touch_txn_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tsd_in_if #(.ADC_BITS(ADC_BITS)) in_ch ();
    tsd_out_if                       out_ch ();

    touch_sensor_window_debouncer_top #(
        .ADC_BITS(ADC_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    touch_txn_t sample_q[$];
    res_t       result_q[$];

    // shadow configuration and debouncer state
    logic             cfg_enable;
    logic [CNT_W-1:0] cfg_deb;
    logic [CNT_W-1:0] cfg_flt;
    cls_t             stable_q = CLS_INVALID;
    cls_t             cand_q   = CLS_INVALID;
    logic [CNT_W-1:0] deb_cnt  = '0;
    logic [CNT_W-1:0] inv_run  = '0;
    logic             fault_q  = 1'b0;

    int tx_gap_max;
    int rx_stall_max;
    int gap_left;
    int stall_left;
    int idle_cycles = 0;
    int errors      = 0;
    int n_sent      = 0;
    int n_checked   = 0;
    int n_changes   = 0;
    int n_faults    = 0;
    int n_settings;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic cls_t classify_sample(logic [ADC_BITS-1:0] s);
        int mv;
        mv = int'(s) * MV_FULL_SCALE / ADC_FULL;
        if (mv > MV_PRESS_LO && mv < MV_PRESS_HI)
            return CLS_PRESSED;
        if (mv > MV_RELEASE)
            return CLS_RELEASED;
        return CLS_INVALID;
    endfunction

    function automatic void track_invalid_run(cls_t c);
        if (c == CLS_INVALID)
        begin
            if (inv_run != CNT_MAX)
                inv_run = inv_run + 1'b1;
            if (inv_run >= cfg_flt)
                fault_q = 1'b1;
        end
        else
        begin
            inv_run = '0;
            fault_q = 1'b0;
        end
    endfunction

    function automatic res_t predict_touch(logic op, logic [ADC_BITS-1:0] s);
        res_t r;
        cls_t c;
        logic chg;
        c   = classify_sample(s);
        chg = 1'b0;
        if (op == OP_BASELINE)
        begin
            track_invalid_run(c);
            stable_q = c;
        end
        else if (cfg_enable)
        begin
            track_invalid_run(c);
            if (c != stable_q)
            begin
                if (c == cand_q)
                begin
                    if (deb_cnt != CNT_MAX)
                        deb_cnt = deb_cnt + 1'b1;
                    if (deb_cnt >= cfg_deb)
                    begin
                        stable_q = c;
                        deb_cnt  = '0;
                        chg      = 1'b1;
                    end
                end
                else
                begin
                    cand_q  = c;
                    deb_cnt = 8'd1;
                end
            end
            else
            begin
                deb_cnt = '0;
            end
        end
        r.raw_class = c;
        r.stable    = stable_q;
        r.changed   = chg;
        r.fault     = fault_q;
        return r;
    endfunction

    function automatic logic [ADC_BITS-1:0] sample_in_class(cls_t c);
        case (c)
            CLS_PRESSED:  return ADC_BITS'($urandom_range(PRESS_MIN, PRESS_MAX));
            CLS_RELEASED: return ADC_BITS'($urandom_range(RELEASE_MIN, ADC_FULL));
            default:
                if ($urandom_range(0, 1) == 0)
                    return ADC_BITS'($urandom_range(0, PRESS_MIN - 1));
                else
                    return ADC_BITS'($urandom_range(PRESS_MAX + 1, RELEASE_MIN - 1));
        endcase
    endfunction

    task automatic push_item(logic op, logic [ADC_BITS-1:0] s);
        touch_txn_t t;
        t.op     = op;
        t.sample = s;
        sample_q.push_back(t);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (sample_q.size() != 0 || in_ch.valid || result_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic set_config(logic en, logic [CNT_W-1:0] deb, logic [CNT_W-1:0] flt);
        int pick;
        wait_idle();
        write_reg(REG_ENABLE, {{(CFG_DATA_W-1){1'b0}}, en});
        write_reg(REG_DEBOUNCE_THR, deb);
        write_reg(REG_FAULT_THR, flt);
        @(posedge clk);
        cfg_we     <= 1'b0;
        cfg_enable = en;
        cfg_deb    = deb;
        cfg_flt    = flt;
        n_settings++;
        pick = $urandom_range(0, 2);
        tx_gap_max = (pick == 0) ? 0 : (pick == 1) ? 4 : 18;
        pick = $urandom_range(0, 2);
        rx_stall_max = (pick == 0) ? 0 : (pick == 1) ? 4 : 18;
    endtask

    task automatic long_run(cls_t c, int len);
        for (int k = 0; k < len; k++)
            push_item(OP_POLL, sample_in_class(c));
    endtask

    // runs of one class around the debounce threshold (capped at 5), with noise in between
    task automatic gen_runs(int budget);
        int   n;
        int   len;
        int   lim;
        cls_t c;
        logic op;
        n = 0;
        while (n < budget)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                push_item(logic'($urandom_range(0, 1)), ADC_BITS'($urandom_range(0, ADC_FULL)));
                n++;
            end
            else
            begin
                c   = cls_t'($urandom_range(0, 2));
                lim = (cfg_deb > 5) ? 5 : int'(cfg_deb);
                len = $urandom_range(1, lim + 2);
                for (int k = 0; k < len; k++)
                begin
                    op = ($urandom_range(0, 11) == 0) ? OP_BASELINE : OP_POLL;
                    push_item(op, sample_in_class(c));
                end
                n += len;
            end
        end
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin : drv
        touch_txn_t t;
        res_t       r;
        if (!rst_n)
        begin
            in_ch.valid      <= 1'b0;
            in_ch.opcode     <= 1'b0;
            in_ch.adc_sample <= '0;
            gap_left = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                r = predict_touch(in_ch.opcode, in_ch.adc_sample);
                result_q.push_back(r);
                n_sent++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end
                else if (sample_q.size() > 0)
                begin
                    t = sample_q.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.opcode     <= t.op;
                    in_ch.adc_sample <= t.sample;
                    gap_left = $urandom_range(0, tx_gap_max);
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and scoreboard
    always @(posedge clk or negedge rst_n)
    begin : mon
        res_t r;
        logic nxt_ready;
        int   s;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            nxt_ready = out_ch.ready;
            if (out_ch.valid && out_ch.ready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result with no pending transaction");
                    errors++;
                end
                else
                begin
                    r = result_q.pop_front();
                    n_checked++;
                    if (r.changed)
                        n_changes++;
                    if (r.fault)
                        n_faults++;
                    if (out_ch.raw_class !== r.raw_class)
                    begin
                        $error("raw_class expected %0d actual %0d", r.raw_class,
                               out_ch.raw_class);
                        errors++;
                    end
                    if (out_ch.stable_out !== r.stable)
                    begin
                        $error("stable_out expected %0d actual %0d", r.stable,
                               out_ch.stable_out);
                        errors++;
                    end
                    if (out_ch.state_changed !== r.changed)
                    begin
                        $error("state_changed expected %0d actual %0d", r.changed,
                               out_ch.state_changed);
                        errors++;
                    end
                    if (out_ch.fault !== r.fault)
                    begin
                        $error("fault expected %0d actual %0d", r.fault, out_ch.fault);
                        errors++;
                    end
                end
                s = $urandom_range(0, rx_stall_max);
                if (s == 0)
                begin
                    nxt_ready = 1'b1;
                end
                else
                begin
                    nxt_ready  = 1'b0;
                    stall_left = s - 1;
                end
            end
            else if (!out_ch.ready)
            begin
                if (stall_left > 0)
                    stall_left--;
                else
                    nxt_ready = 1'b1;
            end
            out_ch.ready <= nxt_ready;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        cfg_enable       = 1'b0;
        cfg_deb          = DEBOUNCE_THR_RST;
        cfg_flt          = FAULT_THR_RST;
        tx_gap_max       = 3;
        rx_stall_max     = 3;
        n_settings       = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: disabled polls, baselines work regardless
        push_item(OP_POLL, 10'd180);
        push_item(OP_POLL, 10'd0);
        push_item(OP_BASELINE, 10'd1023);
        push_item(OP_BASELINE, 10'd0);
        push_item(OP_BASELINE, 10'd500);
        push_item(OP_POLL, 10'd1000);

        // zero thresholds and window edges
        set_config(1'b1, 8'd0, 8'd0);
        push_item(OP_POLL, 10'd175);
        push_item(OP_POLL, 10'd194);
        push_item(OP_POLL, 10'd174);
        push_item(OP_POLL, 10'd195);
        push_item(OP_POLL, 10'd982);
        push_item(OP_POLL, 10'd983);
        push_item(OP_POLL, 10'd1023);
        push_item(OP_BASELINE, 10'd180);
        push_item(OP_POLL, 10'd1023);
        push_item(OP_POLL, 10'd0);
        push_item(OP_POLL, 10'd1023);

        set_config(1'b1, DEBOUNCE_THR_RST, FAULT_THR_RST);
        gen_runs(100);
        set_config(1'b1, 8'd1, 8'd1);
        gen_runs(100);
        set_config(1'b1, 8'd3, 8'd2);
        gen_runs(100);
        set_config(1'b0, 8'd2, 8'd3);
        gen_runs(60);

        // saturating invalid run, then a switch at the top threshold
        set_config(1'b1, 8'd255, 8'd255);
        long_run(CLS_INVALID, 260);
        long_run(CLS_PRESSED, 257);
        gen_runs(40);

        set_config(1'b1, 8'd0, 8'd0);
        gen_runs(80);
        for (int p = 0; p < 2; p++)
        begin
            set_config(1'b1, CNT_W'($urandom_range(0, 6)), CNT_W'($urandom_range(0, 8)));
            gen_runs(90);
        end
        set_config(1'b1, CNT_W'($urandom_range(0, 255)), CNT_W'($urandom_range(0, 255)));
        gen_runs(60);

        wait_idle();
        $display("%0d transactions sent, %0d results checked over %0d register settings",
                 n_sent, n_checked, n_settings);
        $display("%0d debounced state changes and %0d results with fault set",
                 n_changes, n_faults);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tsd_pkg.sv
rtl/tsd_in_if.sv
rtl/tsd_out_if.sv
rtl/tsd_classify.sv
rtl/tsd_cfg.sv
rtl/tsd_core.sv
rtl/touch_sensor_window_debouncer_top.sv
rtl/tsd_checker.sv
tb/tb_touch_sensor_window_debouncer_top.sv
